// ===== sv/rpdc_pkg.sv =====
// Shared types and constants of the ramped PWM duty commander.
// Depends on nothing; every module of the block imports it.
package rpdc_pkg;

	typedef struct packed {
		logic [1:0] command;
		logic [7:0] data_byte;
	} request_t;

	typedef struct packed {
		logic [6:0] duty_now;
		logic [6:0] duty_target;
		logic       manual_on;
		logic [1:0] packet_status;
	} result_t;

	// Input command codes
	localparam logic [1:0] CMD_BYTE = 2'd0;
	localparam logic [1:0] CMD_END  = 2'd1;
	localparam logic [1:0] CMD_TICK = 2'd2;

	// Packet status codes
	localparam logic [1:0] STAT_NONE   = 2'd0;
	localparam logic [1:0] STAT_REJECT = 2'd1;
	localparam logic [1:0] STAT_EXEC   = 2'd2;

	// Configuration register indexes
	localparam logic [1:0] CFG_UP_STEP   = 2'd0;
	localparam logic [1:0] CFG_DOWN_STEP = 2'd1;
	localparam logic [1:0] CFG_MAX_DUTY  = 2'd2;
	localparam logic [1:0] CFG_MIN_DUTY  = 2'd3;

	localparam logic [6:0] UP_STEP_RST   = 7'd1;
	localparam logic [6:0] DOWN_STEP_RST = 7'd1;
	localparam logic [6:0] MAX_DUTY_RST  = 7'd100;
	localparam logic [6:0] MIN_DUTY_RST  = 7'd0;
	localparam logic [6:0] DUTY_RST      = 7'd50;

	// Characters and words
	localparam logic [7:0]  CH_DOLLAR   = 8'h24;
	localparam logic [7:0]  CH_CR       = 8'h0D;
	localparam logic [7:0]  CH_P        = 8'h50;
	localparam logic [7:0]  CH_W        = 8'h57;
	localparam logic [7:0]  CH_M        = 8'h4D;
	localparam logic [7:0]  CH_ZERO     = 8'h30;
	localparam logic [7:0]  CH_NINE     = 8'h39;
	localparam logic [47:0] WORD_MANUAL = "manual";
	localparam logic [31:0] WORD_AUTO   = "auto";
	localparam int          MANUAL_LEN  = 6;
	localparam int          AUTO_LEN    = 4;
	localparam int          PWM_LEN     = 5;

	// Leading bytes of a packet kept for decode: '$' plus the longest word
	localparam int HEAD_LEN = 7;

	// Depth of the queue between decode and execution
	localparam int OPQ_DEPTH = 4;

	typedef enum logic [1:0] {
		OP_NONE,
		OP_REJECT,
		OP_EXEC,
		OP_TICK
	} op_kind_t;

	typedef struct packed {
		op_kind_t   kind;
		logic       pwm_ok;
		logic [6:0] pwm_val;
		logic       set_manual;
		logic       set_auto;
	} op_t;

endpackage

// ===== sv/ramped_pwm_duty_commander_core.sv =====
// Ramped PWM duty commander. Requests (packet bytes, end-of-packet marks,
// timer ticks) enter through a queue-style push/full port and each one gives
// exactly one result word on the pop/empty side. The block takes one request
// per clock while full is low and returns one result per clock when pop is
// held and a result is waiting. A request is decoded into the operation queue
// and then executed into the result buffer, both of which are registered. The
// end-of-packet decode works on leading bytes kept in registers, so there is
// no clearing pass after reset. Configuration writes are always ready.
// Depends on rpdc_pkg, rpdc_front, rpdc_opq and rpdc_back.
module ramped_pwm_duty_commander_core #(
	parameter int PACKET_MAX = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  rpdc_pkg::request_t request,
	output logic               empty,
	input  logic               pop,
	output rpdc_pkg::result_t  result,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [6:0]         cfg_data
);
	import rpdc_pkg::*;

	op_t  op_in;
	op_t  op_out;
	logic op_push;
	logic op_full;
	logic op_pop;
	logic op_empty;

	rpdc_front #(
		.PACKET_MAX(PACKET_MAX)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.full    (full),
		.request (request),
		.op_push (op_push),
		.op      (op_in),
		.op_full (op_full)
	);

	rpdc_opq u_opq (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (op_push),
		.full   (op_full),
		.wdata  (op_in),
		.pop    (op_pop),
		.empty  (op_empty),
		.rdata  (op_out)
	);

	rpdc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.op_empty  (op_empty),
		.op        (op_out),
		.op_pop    (op_pop),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.result    (result),
		.empty     (empty),
		.pop       (pop)
	);

endmodule

// ===== sv/rpdc_front.sv =====
// Front end: takes request words, collects packet bytes and decodes
// framing and commands at packet end. Uses rpdc_pkg.
module rpdc_front #(
	parameter int PACKET_MAX = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  rpdc_pkg::request_t request,
	output logic               op_push,
	output rpdc_pkg::op_t      op,
	input  logic               op_full
);
	import rpdc_pkg::*;

	localparam int CW = $clog2(PACKET_MAX + 1);

	logic [CW-1:0] count_q;
	logic          overflow_q;
	logic [7:0]    head_q [HEAD_LEN];
	logic [7:0]    last_q;
	logic [7:0]    prev_q;

	logic          accept;
	logic          is_byte;
	logic          room;
	logic          has_cr;
	logic [CW-1:0] eff_len;
	logic [CW-1:0] ilen;
	logic [7:0]    tail;
	logic          frame_ok;
	logic          is_man;
	logic          is_auto;
	logic          pwm_ok;
	logic [3:0]    tens;
	logic [3:0]    ones;

	assign full    = op_full;
	assign accept  = push && !op_full;
	assign is_byte = request.command == CMD_BYTE;
	assign room    = count_q != CW'(PACKET_MAX);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			overflow_q <= 1'b0;
		end else if (accept) begin
			if (is_byte) begin
				if (room) count_q <= count_q + 1'b1;
				else overflow_q <= 1'b1;
			end else if (request.command == CMD_END) begin
				count_q    <= '0;
				overflow_q <= 1'b0;
			end
		end
	end

	// Keep the leading bytes and the last two bytes of the packet
	always_ff @(posedge clk) begin
		if (accept && is_byte && room) begin
			last_q <= request.data_byte;
			prev_q <= last_q;
			if (count_q < CW'(HEAD_LEN)) head_q[count_q[2:0]] <= request.data_byte;
		end
	end

	// Framing: drop one trailing CR, then need "$" + at least one char + "$"
	assign has_cr   = last_q == CH_CR;
	assign eff_len  = count_q - CW'(has_cr);
	assign ilen     = eff_len - CW'(2);
	assign tail     = has_cr ? prev_q : last_q;
	assign frame_ok = !overflow_q && (count_q != '0) && (eff_len > CW'(2)) &&
		(head_q[0] == CH_DOLLAR) && (tail == CH_DOLLAR);

	always_comb begin
		is_man  = ilen <= CW'(MANUAL_LEN);
		is_auto = ilen <= CW'(AUTO_LEN);
		for (int k = 0; k < MANUAL_LEN; k++) begin
			if (CW'(k) < ilen && head_q[k+1] != WORD_MANUAL[47-8*k -: 8]) is_man = 1'b0;
		end
		for (int k = 0; k < AUTO_LEN; k++) begin
			if (CW'(k) < ilen && head_q[k+1] != WORD_AUTO[31-8*k -: 8]) is_auto = 1'b0;
		end
	end

	assign pwm_ok = (ilen == CW'(PWM_LEN)) && head_q[1] == CH_P && head_q[2] == CH_W &&
		head_q[3] == CH_M && head_q[4] >= CH_ZERO && head_q[4] <= CH_NINE &&
		head_q[5] >= CH_ZERO && head_q[5] <= CH_NINE;
	assign tens = head_q[4][3:0];
	assign ones = head_q[5][3:0];

	always_comb begin
		op.pwm_ok     = pwm_ok;
		op.pwm_val    = 7'(tens) * 7'd10 + 7'(ones);
		op.set_manual = is_man;
		op.set_auto   = is_auto;
		case (request.command)
			CMD_BYTE: op.kind = OP_NONE;
			CMD_END:  op.kind = frame_ok ? OP_EXEC : OP_REJECT;
			CMD_TICK: op.kind = OP_TICK;
			default:  op.kind = OP_NONE;
		endcase
	end

	assign op_push = accept;

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(PACKET_MAX))
		else $error("packet byte count past store size");
	a_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		accept && request.command == CMD_END |=> count_q == '0 && !overflow_q)
		else $error("packet state not cleared at packet end");
	a_overflow_set: assert property (@(posedge clk) disable iff (!arst_n)
		accept && is_byte && !room |=> overflow_q)
		else $error("byte into full store did not mark overflow");
`endif

endmodule

// ===== sv/rpdc_opq.sv =====
// Short queue of decoded operations between the front and back ends.
// Uses rpdc_pkg for the operation type and depth.
module rpdc_opq (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	output logic          full,
	input  rpdc_pkg::op_t wdata,
	input  logic          pop,
	output logic          empty,
	output rpdc_pkg::op_t rdata
);
	import rpdc_pkg::*;

	localparam int PW = $clog2(OPQ_DEPTH);

	op_t           mem_q [OPQ_DEPTH];
	logic [PW-1:0] wptr_q;
	logic [PW-1:0] rptr_q;
	logic [PW:0]   cnt_q;
	logic          do_push;
	logic          do_pop;

	assign full    = cnt_q == (PW+1)'(OPQ_DEPTH);
	assign empty   = cnt_q == '0;
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (do_push) mem_q[wptr_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (do_push) wptr_q <= wptr_q + 1'b1;
			if (do_pop) rptr_q <= rptr_q + 1'b1;
			cnt_q <= cnt_q + (PW+1)'(do_push) - (PW+1)'(do_pop);
		end
	end

`ifndef SYNTHESIS
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= (PW+1)'(OPQ_DEPTH))
		else $error("operation queue count past depth");
	a_ptr_gap: assert property (@(posedge clk) disable iff (!arst_n)
		!full && !empty |-> wptr_q != rptr_q)
		else $error("operation queue pointers meet while partly filled");
	a_push_fills: assert property (@(posedge clk) disable iff (!arst_n)
		do_push && !do_pop |=> !empty)
		else $error("operation queue empty after a push");
`endif

endmodule

// ===== sv/rpdc_back.sv =====
// Back end: holds duty state and configuration, executes decoded
// operations and queues result words. Uses rpdc_pkg.
module rpdc_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              op_empty,
	input  rpdc_pkg::op_t     op,
	output logic              op_pop,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [1:0]        cfg_index,
	input  logic [6:0]        cfg_data,
	output rpdc_pkg::result_t result,
	output logic              empty,
	input  logic              pop
);
	import rpdc_pkg::*;

	logic [6:0] up_q;
	logic [6:0] down_q;
	logic [6:0] max_q;
	logic [6:0] min_q;
	logic [6:0] cur_q;
	logic [6:0] tgt_q;
	logic       man_q;
	logic       trend_q;

	result_t    res_q [2];
	logic       wptr_q;
	logic       rptr_q;
	logic [1:0] cnt_q;

	logic              exec;
	logic              do_pop;
	logic              apply_tgt;
	logic signed [8:0] sweep;
	logic signed [8:0] desired;
	logic signed [8:0] stepped;
	logic signed [8:0] max_s;
	logic signed [8:0] min_s;
	logic [6:0]        tgt_n;
	logic              trend_n;
	logic [6:0]        cur_n;
	logic              man_n;
	logic [1:0]        status;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			up_q   <= UP_STEP_RST;
			down_q <= DOWN_STEP_RST;
			max_q  <= MAX_DUTY_RST;
			min_q  <= MIN_DUTY_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_UP_STEP:   up_q   <= cfg_data;
				CFG_DOWN_STEP: down_q <= cfg_data;
				CFG_MAX_DUTY:  max_q  <= cfg_data;
				CFG_MIN_DUTY:  min_q  <= cfg_data;
				default:       up_q   <= up_q;
			endcase
		end
	end

	assign exec   = !op_empty && cnt_q != 2'd2;
	assign op_pop = exec;
	assign do_pop = pop && cnt_q != 2'd0;
	assign max_s  = $signed({2'b00, max_q});
	assign min_s  = $signed({2'b00, min_q});

	assign sweep = trend_q ? $signed({2'b00, tgt_q}) - $signed({2'b00, down_q})
		: $signed({2'b00, tgt_q}) + $signed({2'b00, up_q});

	always_comb begin
		tgt_n     = tgt_q;
		trend_n   = trend_q;
		cur_n     = cur_q;
		man_n     = man_q;
		status    = STAT_NONE;
		apply_tgt = 1'b0;
		desired   = $signed({2'b00, op.pwm_val});
		stepped   = $signed({2'b00, cur_q});
		case (op.kind)
			OP_TICK: begin
				apply_tgt = !man_q;
				desired   = sweep;
			end
			OP_EXEC: begin
				apply_tgt = op.pwm_ok && man_q;
				status    = STAT_EXEC;
				if (op.set_manual) man_n = 1'b1;
				if (op.set_auto) man_n = 1'b0;
			end
			OP_REJECT: status = STAT_REJECT;
			default: status = STAT_NONE;
		endcase
		// Clamp the target; hitting a limit turns the sweep around
		if (apply_tgt) begin
			if (desired >= max_s) begin
				tgt_n   = max_q;
				trend_n = 1'b1;
			end else if (desired <= min_s) begin
				tgt_n   = min_q;
				trend_n = 1'b0;
			end else begin
				tgt_n = desired[6:0];
			end
		end
		// Step the current duty toward the target, clamped to the limits only
		if (op.kind == OP_TICK && tgt_n != cur_q) begin
			if (tgt_n > cur_q) stepped = $signed({2'b00, cur_q}) + $signed({2'b00, up_q});
			else stepped = $signed({2'b00, cur_q}) - $signed({2'b00, down_q});
			if (stepped >= max_s) cur_n = max_q;
			else if (stepped <= min_s) cur_n = min_q;
			else cur_n = stepped[6:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q   <= DUTY_RST;
			tgt_q   <= DUTY_RST;
			man_q   <= 1'b0;
			trend_q <= 1'b0;
		end else if (exec) begin
			cur_q   <= cur_n;
			tgt_q   <= tgt_n;
			man_q   <= man_n;
			trend_q <= trend_n;
		end
	end

	always_ff @(posedge clk) begin
		if (exec) res_q[wptr_q] <= '{duty_now: cur_n, duty_target: tgt_n,
			manual_on: man_n, packet_status: status};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= 1'b0;
			rptr_q <= 1'b0;
			cnt_q  <= 2'd0;
		end else begin
			if (exec) wptr_q <= !wptr_q;
			if (do_pop) rptr_q <= !rptr_q;
			cnt_q <= cnt_q + 2'(exec) - 2'(do_pop);
		end
	end

	assign result = res_q[rptr_q];
	assign empty  = cnt_q == 2'd0;

`ifndef SYNTHESIS
	a_res_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != 2'd3)
		else $error("result buffer count past depth");
	a_plain_holds: assert property (@(posedge clk) disable iff (!arst_n)
		exec && (op.kind == OP_NONE || op.kind == OP_REJECT)
		|=> $stable(cur_q) && $stable(tgt_q) && $stable(man_q))
		else $error("duty state moved on a byte or rejected packet");
	a_mode_only_exec: assert property (@(posedge clk) disable iff (!arst_n)
		!(exec && op.kind == OP_EXEC) |=> $stable(man_q))
		else $error("mode changed outside an executed packet");
	a_exec_shows: assert property (@(posedge clk) disable iff (!arst_n)
		exec |=> !empty)
		else $error("executed operation left no result");
`endif

endmodule
